/* rtl/core/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the passive TCP connection block
// Connection states, request and status codes, flag bits, config indexes.
// ----------------------------------------------------------------------------
package tpc_pkg;

  // RFC 793 state numbering
  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RCVD    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_FIN_WAIT_1  = 4'd5,
    ST_FIN_WAIT_2  = 4'd6,
    ST_CLOSE_WAIT  = 4'd7,
    ST_CLOSING     = 4'd8,
    ST_LAST_ACK    = 4'd9,
    ST_TIME_WAIT   = 4'd10
  } conn_state_e;

  typedef enum logic [1:0] {
    REQ_SEGMENT = 2'd0,
    REQ_SEND    = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_LISTEN  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_HANDLED = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_ILLEGAL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_LOCAL_PORT  = 2'd0,
    CFG_INITIAL_SEQ = 2'd1,
    CFG_SEND_WINDOW = 2'd2
  } cfg_index_e;

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  localparam logic [15:0] SEND_WINDOW_RESET = 16'd512;

  // One request beat
  typedef struct packed {
    req_type_e   req_type;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [15:0] payload_len;
  } req_t;

  // Connection context
  typedef struct packed {
    conn_state_e state;
    logic [31:0] send_next;
    logic [31:0] recv_next;
    logic [15:0] peer_port;
  } ctx_t;

  // Configuration registers
  typedef struct packed {
    logic [15:0] local_port;
    logic [31:0] initial_seq;
    logic [15:0] send_window;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic        send_valid;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] window;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic        deliver_payload;
    status_e     status;
    conn_state_e conn_state;
  } result_t;

endpackage

/* rtl/core/tpc_step.sv */
// ----------------------------------------------------------------------------
// tpc_step: next-context and reply-header logic for one request
// Pure combinational step from the current context, config and request.
// ----------------------------------------------------------------------------
module tpc_step (
  input  tpc_pkg::req_t    req_i,
  input  tpc_pkg::ctx_t    ctx_i,
  input  tpc_pkg::cfg_t    cfg_i,
  output tpc_pkg::ctx_t    ctx_o,
  output tpc_pkg::result_t res_o
);
  import tpc_pkg::*;

  logic [31:0] seq_plus_one;
  logic [31:0] seq_plus_len;
  logic        port_closed;

  assign seq_plus_one = req_i.seg_seq + 32'd1;
  assign seq_plus_len = req_i.seg_seq + {16'd0, req_i.payload_len};
  assign port_closed  = (req_i.seg_dst_port != cfg_i.local_port) ||
                        (ctx_i.state == ST_CLOSED) ||
                        (ctx_i.state == ST_CLOSE_WAIT) ||
                        (ctx_i.state == ST_TIME_WAIT);

  always_comb begin
    ctx_o = ctx_i;
    res_o = '0;
    res_o.status = STATUS_HANDLED;

    case (req_i.req_type)
      REQ_SEGMENT: begin
        if (port_closed) begin
          // Refuse with RST-ACK, ports swapped
          res_o.send_valid = 1'b1;
          res_o.flags      = FL_RST | FL_ACK;
          res_o.ack        = seq_plus_one;
          res_o.src_port   = req_i.seg_dst_port;
          res_o.dest_port  = req_i.seg_src_port;
        end else begin
          case (ctx_i.state)
            ST_LISTEN: begin
              if (req_i.seg_flags == FL_SYN) begin
                ctx_o.peer_port  = req_i.seg_src_port;
                ctx_o.recv_next  = seq_plus_one;
                ctx_o.send_next  = cfg_i.initial_seq + 32'd1;
                ctx_o.state      = ST_SYN_RCVD;
                res_o.send_valid = 1'b1;
                res_o.flags      = FL_SYN | FL_ACK;
                res_o.seq        = cfg_i.initial_seq;
                res_o.ack        = seq_plus_one;
                res_o.window     = cfg_i.send_window;
                res_o.src_port   = cfg_i.local_port;
                res_o.dest_port  = req_i.seg_src_port;
              end else begin
                res_o.status = STATUS_IGNORED;
              end
            end
            ST_SYN_RCVD: begin
              if ((req_i.seg_seq == ctx_i.recv_next) &&
                  (req_i.seg_ack == ctx_i.send_next) &&
                  ((req_i.seg_flags & FL_ACK) != 8'd0)) begin
                ctx_o.state = ST_ESTABLISHED;
              end else begin
                res_o.status = STATUS_IGNORED;
              end
            end
            ST_ESTABLISHED: begin
              if (((req_i.seg_flags & FL_PSH) != 8'd0) &&
                  ((req_i.seg_flags & FL_ACK) != 8'd0)) begin
                ctx_o.send_next       = req_i.seg_ack;
                ctx_o.recv_next       = seq_plus_len;
                res_o.send_valid      = 1'b1;
                res_o.flags           = FL_ACK;
                res_o.seq             = req_i.seg_ack;
                res_o.ack             = seq_plus_len;
                res_o.window          = cfg_i.send_window;
                res_o.src_port        = cfg_i.local_port;
                res_o.dest_port       = req_i.seg_src_port;
                res_o.deliver_payload = 1'b1;
              end else if ((req_i.seg_flags & FL_FIN) != 8'd0) begin
                ctx_o.send_next  = req_i.seg_ack;
                ctx_o.recv_next  = seq_plus_len + 32'd1;
                ctx_o.peer_port  = req_i.seg_src_port;
                ctx_o.state      = ST_CLOSE_WAIT;
                res_o.send_valid = 1'b1;
                res_o.flags      = FL_ACK;
                res_o.seq        = req_i.seg_ack;
                res_o.ack        = seq_plus_len + 32'd1;
                res_o.window     = cfg_i.send_window;
                res_o.src_port   = cfg_i.local_port;
                res_o.dest_port  = req_i.seg_src_port;
              end else begin
                res_o.status = STATUS_IGNORED;
              end
            end
            ST_LAST_ACK: begin
              if ((req_i.seg_flags & FL_ACK) != 8'd0) begin
                ctx_o.state = ST_CLOSED;
              end else begin
                res_o.status = STATUS_IGNORED;
              end
            end
            default: begin
              res_o.status = STATUS_IGNORED;
            end
          endcase
        end
      end
      REQ_SEND: begin
        if (ctx_i.state == ST_ESTABLISHED) begin
          res_o.send_valid = 1'b1;
          res_o.flags      = FL_PSH | FL_ACK;
          res_o.seq        = ctx_i.send_next;
          res_o.ack        = ctx_i.recv_next;
          res_o.window     = cfg_i.send_window;
          res_o.src_port   = cfg_i.local_port;
          res_o.dest_port  = ctx_i.peer_port;
          ctx_o.send_next  = ctx_i.send_next + {16'd0, req_i.payload_len};
        end else begin
          res_o.status = STATUS_ILLEGAL;
        end
      end
      REQ_TICK: begin
        if (ctx_i.state == ST_CLOSE_WAIT) begin
          res_o.send_valid = 1'b1;
          res_o.flags      = FL_FIN | FL_ACK;
          res_o.seq        = ctx_i.send_next;
          res_o.ack        = ctx_i.recv_next;
          res_o.window     = cfg_i.send_window;
          res_o.src_port   = cfg_i.local_port;
          res_o.dest_port  = ctx_i.peer_port;
          ctx_o.send_next  = ctx_i.send_next + 32'd1;
          ctx_o.state      = ST_LAST_ACK;
        end
      end
      REQ_LISTEN: begin
        if (ctx_i.state == ST_CLOSED) begin
          ctx_o.state = ST_LISTEN;
        end else begin
          res_o.status = STATUS_ILLEGAL;
        end
      end
      default: begin
        res_o.status = STATUS_ILLEGAL;
      end
    endcase

    res_o.conn_state = ctx_o.state;
  end

endmodule

/* rtl/core/tcp_passive_connection_fsm.sv */
// ----------------------------------------------------------------------------
// tcp_passive_connection_fsm: single passive-open TCP connection context
// Takes listen, segment, send and tick requests; returns one result each.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_ready_o): one beat per request, with
//   the request type and the header fields of a received segment.
//   Result channel (out_valid_o / out_ready_i): exactly one beat per
//   request, carrying an optional reply header (send_valid_o), the
//   payload-delivery flag, a status code and the state after the step.
//   Config channel (cfg_valid_i / cfg_ready_o): always ready; index 0 is
//   the local port, 1 the initial send sequence, 2 the advertised window.
//   Write config only while no request is in flight.
// Pipeline and throughput:
//   A request beat lands in the input register; when it advances, the
//   step logic updates the context and fills the result register, where
//   the receiver takes the result. One request per cycle is sustained
//   while the receiver keeps out_ready_i high: the context update is
//   made of compares and 32-bit adds.
// Reset:
//   Context goes to CLOSED with zero sequence numbers and peer port;
//   config returns to port 0, initial sequence 0, window 512.
// Stall:
//   While the result waits, the input register still takes one beat;
//   ready drops only when both registers hold an unfinished beat.
// ----------------------------------------------------------------------------
module tcp_passive_connection_fsm (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  seg_flags_i,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_ack_i,
  input  logic [15:0] seg_src_port_i,
  input  logic [15:0] seg_dst_port_i,
  input  logic [15:0] payload_len_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_valid_o,
  output logic [7:0]  out_flags_o,
  output logic [31:0] out_seq_o,
  output logic [31:0] out_ack_o,
  output logic [15:0] out_window_o,
  output logic [15:0] out_src_port_o,
  output logic [15:0] out_dst_port_o,
  output logic        deliver_payload_o,
  output logic [1:0]  status_o,
  output logic [3:0]  conn_state_out_o,
  // config channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tpc_pkg::*;

  logic    in_valid_q;
  req_t    req_q;
  logic    out_valid_q;
  result_t res_q;
  ctx_t    ctx_q;
  ctx_t    ctx_d;
  cfg_t    cfg_q;
  result_t res_d;
  logic    advance;

  // Move a beat from the input register to the result register when the
  // result slot is empty or being drained this cycle.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  tpc_step u_step (
    .req_i (req_q),
    .ctx_i (ctx_q),
    .cfg_i (cfg_q),
    .ctx_o (ctx_d),
    .res_o (res_d)
  );

  // Input register: valid bit under reset, payload without
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.req_type     <= req_type_e'(req_type_i);
      req_q.seg_flags    <= seg_flags_i;
      req_q.seg_seq      <= seg_seq_i;
      req_q.seg_ack      <= seg_ack_i;
      req_q.seg_src_port <= seg_src_port_i;
      req_q.seg_dst_port <= seg_dst_port_i;
      req_q.payload_len  <= payload_len_i;
    end
  end

  // Connection context: commit on every advancing beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state     <= ST_CLOSED;
      ctx_q.send_next <= '0;
      ctx_q.recv_next <= '0;
      ctx_q.peer_port <= '0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  // Config registers; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_port  <= '0;
      cfg_q.initial_seq <= '0;
      cfg_q.send_window <= SEND_WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LOCAL_PORT:  cfg_q.local_port  <= cfg_data_i[15:0];
        CFG_INITIAL_SEQ: cfg_q.initial_seq <= cfg_data_i;
        CFG_SEND_WINDOW: cfg_q.send_window <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign send_valid_o      = res_q.send_valid;
  assign out_flags_o       = res_q.flags;
  assign out_seq_o         = res_q.seq;
  assign out_ack_o         = res_q.ack;
  assign out_window_o      = res_q.window;
  assign out_src_port_o    = res_q.src_port;
  assign out_dst_port_o    = res_q.dest_port;
  assign deliver_payload_o = res_q.deliver_payload;
  assign status_o          = res_q.status;
  assign conn_state_out_o  = res_q.conn_state;

endmodule

/* rtl/core/tpc_checker.sv */
// ----------------------------------------------------------------------------
// tpc_checker: port-level checks for the passive TCP connection block
// Watches the result channel only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        send_valid_o,
  input logic [7:0]  out_flags_o,
  input logic [31:0] out_seq_o,
  input logic [15:0] out_window_o,
  input logic [15:0] out_dst_port_o,
  input logic        deliver_payload_o,
  input logic [1:0]  status_o
);
  import tpc_pkg::*;

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_flags_o) &&
      $stable(out_seq_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // No header means an all-zero header
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |-> out_flags_o == 8'd0 &&
      out_seq_o == 32'd0 && out_window_o == 16'd0 && out_dst_port_o == 16'd0)
    else $error("header fields set without send_valid");

  // An illegal request never emits a header
  a_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_ILLEGAL |-> !send_valid_o)
    else $error("header emitted for an illegal request");

  // Payload delivery always comes with a plain ACK reply
  a_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deliver_payload_o |->
      send_valid_o && out_flags_o == FL_ACK && status_o == STATUS_HANDLED)
    else $error("payload delivered without an ACK reply");

  // A reset reply advertises no window
  a_rst_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o && out_flags_o == (FL_RST | FL_ACK) |->
      out_window_o == 16'd0 && out_seq_o == 32'd0)
    else $error("RST-ACK with nonzero window or sequence");

endmodule

bind tcp_passive_connection_fsm tpc_checker u_tpc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .send_valid_o      (send_valid_o),
  .out_flags_o       (out_flags_o),
  .out_seq_o         (out_seq_o),
  .out_window_o      (out_window_o),
  .out_dst_port_o    (out_dst_port_o),
  .deliver_payload_o (deliver_payload_o),
  .status_o          (status_o)
);
